>>> rtl/core/tssd_pkg.sv
// Shared types, constants and CRC function for the scratchpad decoder.
package tssd_pkg;

    localparam int FRAME_BYTES = 9;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int RAW_W       = 16;
    localparam int MC_W        = 18;
    localparam int PROD_W      = 23;
    localparam int MC_MIN      = -55000;
    localparam int MC_MAX      = 125000;
    localparam logic [7:0] CRC_POLY = 8'h8C;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_CRC_ERR   = 2'd1,
        STATUS_RANGE_ERR = 2'd2
    } status_t;

    typedef struct packed {
        logic             crc_ok;
        logic [RAW_W-1:0] raw;
    } frame_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] crc;
        logic [7:0] d;
        logic       mix;
        crc = crc_in;
        d   = data;
        for (int i = 0; i < 8; i++)
        begin
            mix = crc[0] ^ d[0];
            crc = crc >> 1;
            if (mix)
            begin
                crc = crc ^ CRC_POLY;
            end
            d = d >> 1;
        end
        return crc;
    endfunction

endpackage

>>> rtl/core/tssd_in_if.sv
// Input channel: one scratchpad byte per word.
interface tssd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

>>> rtl/core/tssd_out_if.sv
// Output channel: one decoded temperature per word.
interface tssd_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [tssd_pkg::MC_W-1:0] milli_celsius;
    logic [1:0]                       status;

    modport source (output valid, output milli_celsius, output status, input ready);
    modport sink   (input valid, input milli_celsius, input status, output ready);
endinterface

>>> rtl/core/temp_sensor_scratchpad_decoder.sv
// Temperature sensor scratchpad decoder, top level.
// Takes one scratchpad byte per cycle with no bubbles while the queue is not
// full; the front end updates the CRC-8 for each byte, and on the last byte
// of a frame (byte FRAME_BYTES-1, counted from frame_start or the previous
// frame end) hands the frame to a two-entry queue. The back end scales it,
// checks range and CRC, and presents the result from an output register, which
// takes the queue head when the output is free. Input ready drops only when
// the queue is full, i.e. when two finished frames wait behind a stalled output.
module temp_sensor_scratchpad_decoder (
    input  logic       clk,
    input  logic       rst_n,
    tssd_in_if.sink    scratchpad,
    tssd_out_if.source reading
);

    logic             push;
    logic             pop;
    logic             full;
    logic             not_empty;
    tssd_pkg::frame_t push_entry;
    tssd_pkg::frame_t head;

    tssd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .scratchpad (scratchpad),
        .queue_full (full),
        .push       (push),
        .push_entry (push_entry)
    );

    tssd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .not_empty  (not_empty),
        .head       (head)
    );

    tssd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .result    (reading)
    );

endmodule

>>> rtl/core/tssd_front.sv
// Front end: byte counting, CRC-8 accumulation and raw temperature capture.
module tssd_front (
    input  logic            clk,
    input  logic            rst_n,
    tssd_in_if.sink         scratchpad,
    input  logic            queue_full,
    output logic            push,
    output tssd_pkg::frame_t push_entry
);

    logic [tssd_pkg::IDX_W-1:0] idx_reg, idx_next, idx_eff;
    logic [7:0]                 crc_reg, crc_next, crc_eff;
    logic [tssd_pkg::RAW_W-1:0] raw_reg, raw_next;
    logic                       accept;
    logic                       last;

    assign scratchpad.ready = !queue_full;
    assign accept  = scratchpad.valid && scratchpad.ready;
    assign idx_eff = scratchpad.frame_start ? '0 : idx_reg;
    assign crc_eff = scratchpad.frame_start ? 8'd0 : crc_reg;
    assign last    = (idx_eff == tssd_pkg::LAST_IDX);

    assign push              = accept && last;
    assign push_entry.crc_ok = (scratchpad.data_byte == crc_eff);
    assign push_entry.raw    = raw_reg;

    always_comb
    begin
        idx_next = idx_reg;
        crc_next = crc_reg;
        raw_next = raw_reg;
        if (accept)
        begin
            if (last)
            begin
                idx_next = '0;
                crc_next = 8'd0;
            end
            else
            begin
                idx_next = idx_eff + 1'b1;
                crc_next = tssd_pkg::crc8_byte(crc_eff, scratchpad.data_byte);
                if (idx_eff == '0)
                begin
                    raw_next[7:0] = scratchpad.data_byte;
                end
                else if (idx_eff == tssd_pkg::IDX_W'(1))
                begin
                    raw_next[15:8] = scratchpad.data_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            crc_reg <= 8'd0;
            raw_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            crc_reg <= crc_next;
            raw_reg <= raw_next;
        end
    end

endmodule

>>> rtl/core/tssd_queue.sv
// Two-entry queue of completed frames between front and back end.
module tssd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tssd_pkg::frame_t push_entry,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output tssd_pkg::frame_t head
);

    tssd_pkg::frame_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/core/tssd_back.sv
// Back end: scaling to millidegrees, CRC and range status, and output register.
module tssd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             not_empty,
    input  tssd_pkg::frame_t head,
    output logic             pop,
    tssd_out_if.source       result
);

    logic                               valid_reg, valid_next;
    logic signed [tssd_pkg::MC_W-1:0]   mc_reg, mc_next;
    tssd_pkg::status_t                  status_reg, status_next;
    logic signed [tssd_pkg::PROD_W-1:0] prod, prod_adj;
    logic signed [tssd_pkg::PROD_W-2:0] mc_full;
    logic                               in_range;

    // raw*625/10 == raw*125/2, truncated toward zero
    assign prod     = $signed({{(tssd_pkg::PROD_W - tssd_pkg::RAW_W){head.raw[15]}}, head.raw})
                      * $signed(tssd_pkg::PROD_W'(125));
    assign prod_adj = prod + $signed({{(tssd_pkg::PROD_W - 1){1'b0}}, prod[tssd_pkg::PROD_W-1]});
    assign mc_full  = prod_adj[tssd_pkg::PROD_W-1:1];
    assign in_range = (mc_full >= tssd_pkg::MC_MIN) && (mc_full <= tssd_pkg::MC_MAX);

    assign pop = not_empty && (!valid_reg || result.ready);

    always_comb
    begin
        valid_next  = valid_reg;
        mc_next     = mc_reg;
        status_next = status_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            if (!head.crc_ok)
            begin
                status_next = tssd_pkg::STATUS_CRC_ERR;
                mc_next     = '0;
            end
            else if (!in_range)
            begin
                status_next = tssd_pkg::STATUS_RANGE_ERR;
                mc_next     = '0;
            end
            else
            begin
                status_next = tssd_pkg::STATUS_OK;
                mc_next     = mc_full[tssd_pkg::MC_W-1:0];
            end
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mc_reg     <= mc_next;
        status_reg <= status_next;
    end

    assign result.valid         = valid_reg;
    assign result.milli_celsius = mc_reg;
    assign result.status        = status_reg;

endmodule

>>> rtl/core/tssd_checker.sv
// Port-level checks on the decoded output word, bound to the top level.
module tssd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             valid,
    input logic                             ready,
    input logic signed [tssd_pkg::MC_W-1:0] milli_celsius,
    input logic [1:0]                       status
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(milli_celsius) && $stable(status))
        else $error("output word changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (status == tssd_pkg::STATUS_OK) || (status == tssd_pkg::STATUS_CRC_ERR)
                  || (status == tssd_pkg::STATUS_RANGE_ERR))
        else $error("unknown status code");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (status != tssd_pkg::STATUS_OK) |-> milli_celsius == '0)
        else $error("nonzero temperature with error status");

    a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (status == tssd_pkg::STATUS_OK) |->
            (milli_celsius >= tssd_pkg::MC_MIN) && (milli_celsius <= tssd_pkg::MC_MAX))
        else $error("ok temperature out of range");

endmodule

bind temp_sensor_scratchpad_decoder tssd_checker u_tssd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid         (reading.valid),
    .ready         (reading.ready),
    .milli_celsius (reading.milli_celsius),
    .status        (reading.status)
);

>>> test/temp_sensor_scratchpad_decoder_tb.sv
// Self-checking testbench for the scratchpad decoder: directed and random byte streams against a frame predictor.
module temp_sensor_scratchpad_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BYTES = 1100;
    localparam int CALM_TAIL = 120;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [15:0] BOUNDARY_RAWS [10] = '{
        16'h07D0, 16'h07D1, 16'hFC90, 16'hFC8F, 16'h8000,
        16'h7FFF, 16'hFFFF, 16'h0000, 16'h0001, 16'hFFF7
    };

    typedef struct {
        logic [7:0] data;
        logic       start;
    } scratch_word_t;

    typedef struct {
        logic signed [tssd_pkg::MC_W-1:0] mc;
        tssd_pkg::status_t                st;
    } reading_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tssd_in_if  scratchpad_if ();
    tssd_out_if reading_if ();

    temp_sensor_scratchpad_decoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .scratchpad (scratchpad_if.sink),
        .reading    (reading_if.source)
    );

    scratch_word_t scratchpad_words[$];
    reading_t      expected_readings[$];
    scratch_word_t next_word;
    reading_t      got_reading;

    // predictor state
    logic [3:0]  frame_pos = '0;
    logic [7:0]  frame_crc = '0;
    logic [15:0] frame_raw = '0;

    int errors = 0;
    int cycles = 0;
    int send_gap = 0;
    int recv_hold = 0;
    int bytes_sent = 0;
    int ok_frames = 0;
    int crc_frames = 0;
    int range_frames = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
        end
        return c;
    endfunction

    function automatic bit calm_phase();
        return scratchpad_words.size() < CALM_TAIL;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic decode_scratchpad_byte(logic [7:0] data, logic start);
        int       raw_val;
        int       scaled;
        reading_t r;
        if (start)
        begin
            frame_pos = '0;
            frame_crc = '0;
        end
        if (frame_pos < 4'(tssd_pkg::FRAME_BYTES - 1))
        begin
            frame_crc = crc8_next(frame_crc, data);
            if (frame_pos == 4'd0)
                frame_raw[7:0] = data;
            else if (frame_pos == 4'd1)
                frame_raw[15:8] = data;
            frame_pos = frame_pos + 4'd1;
        end
        else
        begin
            if (data != frame_crc)
            begin
                r.st = tssd_pkg::STATUS_CRC_ERR;
                r.mc = '0;
            end
            else
            begin
                raw_val = $signed(frame_raw);
                scaled = (raw_val * 625) / 10;
                if (scaled < tssd_pkg::MC_MIN || scaled > tssd_pkg::MC_MAX)
                begin
                    r.st = tssd_pkg::STATUS_RANGE_ERR;
                    r.mc = '0;
                end
                else
                begin
                    r.st = tssd_pkg::STATUS_OK;
                    r.mc = scaled[tssd_pkg::MC_W-1:0];
                end
            end
            frame_pos = '0;
            frame_crc = '0;
            expected_readings.push_back(r);
        end
    endtask

    task automatic queue_frame(logic [15:0] raw, logic with_start, logic good_crc);
        logic [7:0] b;
        logic [7:0] crc;
        scratch_word_t w;
        crc = '0;
        for (int i = 0; i < tssd_pkg::FRAME_BYTES - 1; i++)
        begin
            b = (i == 0) ? raw[7:0] : (i == 1) ? raw[15:8] : 8'($urandom);
            crc = crc8_next(crc, b);
            w.data = b;
            w.start = (i == 0) ? with_start : 1'b0;
            scratchpad_words.push_back(w);
        end
        w.data = good_crc ? crc : crc ^ 8'($urandom_range(1, 255));
        w.start = 1'b0;
        scratchpad_words.push_back(w);
    endtask

    task automatic queue_noise(int count);
        scratch_word_t w;
        for (int i = 0; i < count; i++)
        begin
            w.data = 8'($urandom);
            w.start = ($urandom_range(0, 3) == 0);
            scratchpad_words.push_back(w);
        end
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scratchpad_if.valid <= 1'b0;
            scratchpad_if.data_byte <= '0;
            scratchpad_if.frame_start <= 1'b0;
        end
        else
        begin
            if (scratchpad_if.valid && scratchpad_if.ready)
            begin
                decode_scratchpad_byte(scratchpad_if.data_byte, scratchpad_if.frame_start);
                bytes_sent++;
            end
            if (!scratchpad_if.valid || scratchpad_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    scratchpad_if.valid <= 1'b0;
                end
                else if (scratchpad_words.size() != 0 && !calm_phase()
                         && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(0, 3);
                    scratchpad_if.valid <= 1'b0;
                end
                else if (scratchpad_words.size() != 0)
                begin
                    next_word = scratchpad_words.pop_front();
                    scratchpad_if.valid <= 1'b1;
                    scratchpad_if.data_byte <= next_word.data;
                    scratchpad_if.frame_start <= next_word.start;
                end
                else
                begin
                    scratchpad_if.valid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reading_if.ready <= 1'b0;
        end
        else
        begin
            if (reading_if.valid && reading_if.ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word mc=%0d status=%0d",
                                              reading_if.milli_celsius, reading_if.status));
                end
                else
                begin
                    got_reading = expected_readings.pop_front();
                    case (got_reading.st)
                        tssd_pkg::STATUS_OK:      ok_frames++;
                        tssd_pkg::STATUS_CRC_ERR: crc_frames++;
                        default:                  range_frames++;
                    endcase
                    if (reading_if.milli_celsius !== got_reading.mc)
                        report_mismatch($sformatf("milli_celsius %0d, want %0d",
                                                  reading_if.milli_celsius, got_reading.mc));
                    if (reading_if.status !== got_reading.st)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  reading_if.status, got_reading.st));
                end
            end
            if (recv_hold > 0)
            begin
                recv_hold--;
                reading_if.ready <= 1'b0;
            end
            else if (!calm_phase() && $urandom_range(0, 5) == 0)
            begin
                recv_hold = $urandom_range(0, 3);
                reading_if.ready <= 1'b0;
            end
            else
            begin
                reading_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d words still expected",
                     cycles, expected_readings.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int sel;
        logic [15:0] raw;
        scratch_word_t w;

        scratchpad_if.valid = 1'b0;
        scratchpad_if.data_byte = '0;
        scratchpad_if.frame_start = 1'b0;
        reading_if.ready = 1'b0;

        // directed: top of range, aborted short frame, below range, crc error with implicit start
        queue_frame(16'h07D0, 1'b1, 1'b1);
        w.data = 8'hFF;
        w.start = 1'b1;
        scratchpad_words.push_back(w);
        w.data = 8'h00;
        w.start = 1'b0;
        scratchpad_words.push_back(w);
        w.data = 8'hA5;
        scratchpad_words.push_back(w);
        queue_frame(16'hFC8F, 1'b1, 1'b1);
        queue_frame(16'hFFFF, 1'b0, 1'b0);

        while (scratchpad_words.size() < RANDOM_BYTES + 30)
        begin
            sel = $urandom_range(0, 19);
            if (sel < 3)
            begin
                queue_noise($urandom_range(1, 12));
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: raw = BOUNDARY_RAWS[$urandom_range(0, 9)];
                    4, 5, 6, 7: raw = 16'($signed($urandom_range(0, 2880)) - 880);
                    default:    raw = 16'($urandom);
                endcase
                queue_frame(raw, $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0);
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (scratchpad_words.size() != 0 || scratchpad_if.valid)
            @(posedge clk);
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d scratchpad bytes; checked %0d ok, %0d crc-error, %0d out-of-range",
                 bytes_sent, ok_frames, crc_frames, range_frames);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> temp_sensor_scratchpad_decoder.f
rtl/core/tssd_pkg.sv
rtl/core/tssd_in_if.sv
rtl/core/tssd_out_if.sv
rtl/core/tssd_front.sv
rtl/core/tssd_queue.sv
rtl/core/tssd_back.sv
rtl/core/temp_sensor_scratchpad_decoder.sv
rtl/core/tssd_checker.sv
test/temp_sensor_scratchpad_decoder_tb.sv
